// ===== design/differential_drive_wheel_speed_defines.svh =====
// assertion macros for the wheel speed block
// used by differential_drive_wheel_speed.sv only
`ifndef DIFFERENTIAL_DRIVE_WHEEL_SPEED_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_WHEEL_SPEED_DEFINES_SVH
`ifndef SYNTH
`define DDWS_ASSERT_IMPL(label, c, r, a, b) \
    label: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
        else $error("ddws assertion failed");
`define DDWS_ASSERT_NEVER(label, c, r, a) \
    label: assert property (@(posedge c) disable iff (!r) !(a)) \
        else $error("ddws forbidden condition");
`else
`define DDWS_ASSERT_IMPL(label, c, r, a, b)
`define DDWS_ASSERT_NEVER(label, c, r, a)
`endif
`endif

// ===== design/ddws_pkg.sv =====
// shared constants, types and saturation helpers for the wheel speed block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ddws_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int REG_W     = 31;
    localparam int PROD_W    = DATA_W + REG_W;
    localparam int DIV_STEPS = REG_W;
    localparam int LATENCY   = 3 + DIV_STEPS + 2;

    typedef enum logic [1:0] {
        CFG_HALF_TRACK   = 2'd0,
        CFG_SPEED_LIMIT  = 2'd1,
        CFG_RADIUS_RECIP = 2'd2
    } cfg_idx_t;

    // word handed from the mixing stages to the two dividers
    typedef struct packed {
        logic                     vld;
        logic                     limited;
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;
        logic [PROD_W-1:0]        dvd_l;
        logic [PROD_W-1:0]        dvd_r;
        logic [DATA_W-1:0]        mx;
    } mix_word_t;

    localparam logic signed [PROD_W-1:0] P_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] P_MIN = PROD_W'(-64'sd2147483648);
    localparam logic signed [DATA_W+1:0] S_MAX = (DATA_W+2)'(64'sd2147483647);
    localparam logic signed [DATA_W+1:0] S_MIN = (DATA_W+2)'(-64'sd2147483648);

    // floor shift of a product, saturated to 32 bits
    function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        sh = p >>> FRAC_BITS;
        if (sh > P_MAX)
            return P_MAX[DATA_W-1:0];
        else if (sh < P_MIN)
            return P_MIN[DATA_W-1:0];
        return sh[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W+1:0] s);
        if (s > S_MAX)
            return S_MAX[DATA_W-1:0];
        else if (s < S_MIN)
            return S_MIN[DATA_W-1:0];
        return s[DATA_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== design/differential_drive_wheel_speed.sv =====
// top level of the differential drive wheel speed block: config registers and pipeline
// depends on ddws_pkg, ddws_mix, ddws_div, ddws_ang and the defines header
//
// channel   handshake          payload
// command   start / busy       speed_x, yaw_rate
// result    done (strobe)      left_linear, right_linear, left_angular, right_angular, limited
// config    cfg_wen            cfg_idx, cfg_wdata
//
// one word accepted per cycle; busy is always low
// pipeline: 3 mixing stages, 31 divider stages (one quotient bit each), 2 output stages
// reset clears the valid bits and loads the register defaults
// results are a one-cycle strobe and cannot be held off
`timescale 1ns / 1ps
`default_nettype none
`include "differential_drive_wheel_speed_defines.svh"
module differential_drive_wheel_speed
    import ddws_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] speed_x,
    input  wire logic signed [DATA_W-1:0] yaw_rate,
    input  wire logic                     cfg_wen,
    input  wire logic [1:0]               cfg_idx,
    input  wire logic [REG_W-1:0]         cfg_wdata,
    output logic                          done,
    output logic signed [DATA_W-1:0]      left_linear,
    output logic signed [DATA_W-1:0]      right_linear,
    output logic signed [DATA_W-1:0]      left_angular,
    output logic signed [DATA_W-1:0]      right_angular,
    output logic                          limited
);
    logic [REG_W-1:0] half_track_reg, speed_limit_reg, radius_recip_reg;
    mix_word_t        mix;
    logic             lim_pipe_reg [DIV_STEPS];
    logic             dl_vld, dr_vld;
    logic signed [DATA_W-1:0] dl_res, dr_res;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_track_reg   <= REG_W'(6554);
            speed_limit_reg  <= REG_W'(65536);
            radius_recip_reg <= REG_W'(1310720);
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                CFG_HALF_TRACK:   half_track_reg   <= cfg_wdata;
                CFG_SPEED_LIMIT:  speed_limit_reg  <= cfg_wdata;
                CFG_RADIUS_RECIP: radius_recip_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    ddws_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (start && !busy),
        .speed_x    (speed_x),
        .yaw_rate   (yaw_rate),
        .half_track (half_track_reg),
        .speed_limit(speed_limit_reg),
        .mix        (mix)
    );

    ddws_div u_div_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (mix.vld),
        .use_div (mix.limited),
        .neg     (mix.left[DATA_W-1]),
        .dividend(mix.dvd_l),
        .divisor (mix.mx),
        .bypass  (mix.left),
        .out_vld (dl_vld),
        .result  (dl_res)
    );

    ddws_div u_div_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (mix.vld),
        .use_div (mix.limited),
        .neg     (mix.right[DATA_W-1]),
        .dividend(mix.dvd_r),
        .divisor (mix.mx),
        .bypass  (mix.right),
        .out_vld (dr_vld),
        .result  (dr_res)
    );

    // limited flag rides alongside the dividers
    always_ff @(posedge clk)
    begin
        lim_pipe_reg[0] <= mix.limited;
        for (int i = 1; i < DIV_STEPS; i++)
            lim_pipe_reg[i] <= lim_pipe_reg[i-1];
    end

    ddws_ang u_ang (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_vld           (dl_vld),
        .in_limited       (lim_pipe_reg[DIV_STEPS-1]),
        .in_left          (dl_res),
        .in_right         (dr_res),
        .radius_reciprocal(radius_recip_reg),
        .done             (done),
        .left_linear      (left_linear),
        .right_linear     (right_linear),
        .left_angular     (left_angular),
        .right_angular    (right_angular),
        .limited          (limited)
    );

    `DDWS_ASSERT_IMPL(a_done_latency, clk, rst_n, done, $past(start && !busy, LATENCY))
    `DDWS_ASSERT_NEVER(a_div_lanes_aligned, clk, rst_n, dl_vld != dr_vld)
    `DDWS_ASSERT_IMPL(a_limit_has_divisor, clk, rst_n, mix.vld && mix.limited, mix.mx != '0)
endmodule
`default_nettype wire

// ===== design/ddws_mix.sv =====
// front stages: turn product, wheel sums, magnitude compare, scaling products
// depends on ddws_pkg
`timescale 1ns / 1ps
`default_nettype none
module ddws_mix
    import ddws_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_vld,
    input  wire logic signed [DATA_W-1:0] speed_x,
    input  wire logic signed [DATA_W-1:0] yaw_rate,
    input  wire logic [REG_W-1:0]         half_track,
    input  wire logic [REG_W-1:0]         speed_limit,
    output mix_word_t                     mix
);
    // stage a
    logic                     a_vld_reg;
    logic signed [DATA_W-1:0] a_vx_reg;
    logic signed [PROD_W-1:0] a_prod_reg;
    logic signed [PROD_W-1:0] a_prod_next;
    // stage b
    logic                     b_vld_reg;
    logic                     b_lim_reg;
    logic signed [DATA_W-1:0] b_left_reg, b_right_reg;
    logic [DATA_W-1:0]        b_ml_reg, b_mr_reg, b_mx_reg;
    logic signed [DATA_W-1:0] turn, left_next, right_next;
    logic [DATA_W-1:0]        ml_next, mr_next, mx_next;
    // stage c
    mix_word_t                c_reg;
    logic [PROD_W-1:0]        dl_next, dr_next;

    assign a_prod_next = yaw_rate * $signed({1'b0, half_track});

    always_comb
    begin
        turn       = sat_prod(a_prod_reg);
        left_next  = sat_sum((DATA_W+2)'(a_vx_reg) - (DATA_W+2)'(turn));
        right_next = sat_sum((DATA_W+2)'(a_vx_reg) + (DATA_W+2)'(turn));
        ml_next    = left_next[DATA_W-1] ? (~left_next + 1'b1) : left_next;
        mr_next    = right_next[DATA_W-1] ? (~right_next + 1'b1) : right_next;
        mx_next    = (ml_next > mr_next) ? ml_next : mr_next;
    end

    assign dl_next = b_ml_reg * speed_limit;
    assign dr_next = b_mr_reg * speed_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_reg     <= '0;
        end
        else
        begin
            a_vld_reg     <= in_vld;
            b_vld_reg     <= a_vld_reg;
            c_reg.vld     <= b_vld_reg;
            c_reg.limited <= b_lim_reg;
            c_reg.left    <= b_left_reg;
            c_reg.right   <= b_right_reg;
            c_reg.dvd_l   <= dl_next;
            c_reg.dvd_r   <= dr_next;
            c_reg.mx      <= b_mx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_vx_reg      <= speed_x;
        a_prod_reg    <= a_prod_next;
        b_left_reg    <= left_next;
        b_right_reg   <= right_next;
        b_ml_reg      <= ml_next;
        b_mr_reg      <= mr_next;
        b_mx_reg      <= mx_next;
        b_lim_reg     <= (mx_next > DATA_W'(speed_limit));
    end

    assign mix = c_reg;
endmodule
`default_nettype wire

// ===== design/ddws_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sign and bypass
// depends on ddws_pkg
`timescale 1ns / 1ps
`default_nettype none
module ddws_div
    import ddws_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_vld,
    input  wire logic                     use_div,
    input  wire logic                     neg,
    input  wire logic [PROD_W-1:0]        dividend,
    input  wire logic [DATA_W-1:0]        divisor,
    input  wire logic signed [DATA_W-1:0] bypass,
    output logic                          out_vld,
    output logic signed [DATA_W-1:0]      result
);
    logic                     vld_reg  [DIV_STEPS];
    logic                     use_reg  [DIV_STEPS];
    logic                     neg_reg  [DIV_STEPS];
    logic [DATA_W-1:0]        rem_reg  [DIV_STEPS];
    logic [REG_W-1:0]         low_reg  [DIV_STEPS];
    logic [REG_W-1:0]         quo_reg  [DIV_STEPS];
    logic [DATA_W-1:0]        dsr_reg  [DIV_STEPS];
    logic signed [DATA_W-1:0] byp_reg  [DIV_STEPS];
    logic [DATA_W-1:0]        quo_ext;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic              p_vld, p_use, p_neg;
        logic [DATA_W-1:0] p_rem, p_dsr;
        logic [REG_W-1:0]  p_low, p_quo;
        logic signed [DATA_W-1:0] p_byp;
        logic [DATA_W:0]   trial;
        logic              fits;

        if (k == 0)
        begin : g_first
            assign p_vld = in_vld;
            assign p_use = use_div;
            assign p_neg = neg;
            assign p_rem = dividend[PROD_W-1:REG_W];
            assign p_low = dividend[REG_W-1:0];
            assign p_quo = '0;
            assign p_dsr = divisor;
            assign p_byp = bypass;
        end
        else
        begin : g_next
            assign p_vld = vld_reg[k-1];
            assign p_use = use_reg[k-1];
            assign p_neg = neg_reg[k-1];
            assign p_rem = rem_reg[k-1];
            assign p_low = low_reg[k-1];
            assign p_quo = quo_reg[k-1];
            assign p_dsr = dsr_reg[k-1];
            assign p_byp = byp_reg[k-1];
        end

        assign trial = {p_rem, p_low[REG_W-1]};
        assign fits  = (trial >= {1'b0, p_dsr});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= p_vld;
        end

        always_ff @(posedge clk)
        begin
            use_reg[k] <= p_use;
            neg_reg[k] <= p_neg;
            rem_reg[k] <= fits ? DATA_W'(trial - {1'b0, p_dsr}) : trial[DATA_W-1:0];
            low_reg[k] <= {p_low[REG_W-2:0], 1'b0};
            quo_reg[k] <= {p_quo[REG_W-2:0], fits};
            dsr_reg[k] <= p_dsr;
            byp_reg[k] <= p_byp;
        end
    end

    // quotient is at most the limit, so it fits in 31 bits
    assign quo_ext = {1'b0, quo_reg[DIV_STEPS-1]};
    assign out_vld = vld_reg[DIV_STEPS-1];
    assign result  = !use_reg[DIV_STEPS-1] ? byp_reg[DIV_STEPS-1] :
                     neg_reg[DIV_STEPS-1] ? $signed(~quo_ext + 1'b1) : $signed(quo_ext);
endmodule
`default_nettype wire

// ===== design/ddws_ang.sv =====
// back stages: angular speed products and the output word register
// depends on ddws_pkg
`timescale 1ns / 1ps
`default_nettype none
module ddws_ang
    import ddws_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_vld,
    input  wire logic                     in_limited,
    input  wire logic signed [DATA_W-1:0] in_left,
    input  wire logic signed [DATA_W-1:0] in_right,
    input  wire logic [REG_W-1:0]         radius_reciprocal,
    output logic                          done,
    output logic signed [DATA_W-1:0]      left_linear,
    output logic signed [DATA_W-1:0]      right_linear,
    output logic signed [DATA_W-1:0]      left_angular,
    output logic signed [DATA_W-1:0]      right_angular,
    output logic                          limited
);
    logic                     d_vld_reg, d_lim_reg;
    logic signed [DATA_W-1:0] d_left_reg, d_right_reg;
    logic signed [PROD_W-1:0] d_pl_reg, d_pr_reg;
    logic signed [PROD_W-1:0] pl_next, pr_next;
    logic                     e_vld_reg, e_lim_reg;
    logic signed [DATA_W-1:0] e_ll_reg, e_rl_reg, e_la_reg, e_ra_reg;

    assign pl_next = in_left * $signed({1'b0, radius_reciprocal});
    assign pr_next = in_right * $signed({1'b0, radius_reciprocal});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= in_vld;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_lim_reg   <= in_limited;
        d_left_reg  <= in_left;
        d_right_reg <= in_right;
        d_pl_reg    <= pl_next;
        d_pr_reg    <= pr_next;
        e_lim_reg   <= d_lim_reg;
        e_ll_reg    <= d_left_reg;
        e_rl_reg    <= d_right_reg;
        e_la_reg    <= sat_prod(d_pl_reg);
        e_ra_reg    <= sat_prod(d_pr_reg);
    end

    assign done          = e_vld_reg;
    assign left_linear   = e_ll_reg;
    assign right_linear  = e_rl_reg;
    assign left_angular  = e_la_reg;
    assign right_angular = e_ra_reg;
    assign limited       = e_lim_reg;
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for differential_drive_wheel_speed: directed, configuration and random command tests
// depends on ddws_pkg and the differential_drive_wheel_speed rtl; self-checking with its own predictor
`timescale 1ns / 1ps
module tb_top;
    import ddws_pkg::*;

    localparam logic [1:0] CFG_NONE = 2'd3;   // no register at this index
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam logic [REG_W-1:0] REG_FULL = {REG_W{1'b1}};

    typedef struct {
        logic signed [DATA_W-1:0] left_lin;
        logic signed [DATA_W-1:0] right_lin;
        logic signed [DATA_W-1:0] left_ang;
        logic signed [DATA_W-1:0] right_ang;
        logic                     scaled;
    } wheel_word_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [DATA_W-1:0] speed_x;
    logic signed [DATA_W-1:0] yaw_rate;
    logic cfg_wen;
    logic [1:0] cfg_idx;
    logic [REG_W-1:0] cfg_wdata;
    logic done;
    logic signed [DATA_W-1:0] left_linear;
    logic signed [DATA_W-1:0] right_linear;
    logic signed [DATA_W-1:0] left_angular;
    logic signed [DATA_W-1:0] right_angular;
    logic limited;

    // local copy of the chassis registers
    logic [REG_W-1:0] track_half;
    logic [REG_W-1:0] wheel_limit;
    logic [REG_W-1:0] inv_radius;

    wheel_word_t wheel_q[$];
    int mismatches;

    differential_drive_wheel_speed dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .speed_x(speed_x), .yaw_rate(yaw_rate),
        .cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .done(done), .left_linear(left_linear), .right_linear(right_linear),
        .left_angular(left_angular), .right_angular(right_angular), .limited(limited)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp32(input longint v);
        if (v > S32_HI)
            return S32_HI;
        if (v < S32_LO)
            return S32_LO;
        return v;
    endfunction

    // floor of the q16.16 product, saturated
    function automatic longint fixed_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> FRAC_BITS);
    endfunction

    function automatic wheel_word_t wheel_speeds(input logic signed [DATA_W-1:0] vx,
                                                 input logic signed [DATA_W-1:0] wz);
        wheel_word_t w;
        longint turn, lft, rgt, ml, mr, mx, lim;
        turn = fixed_mul(longint'(wz), longint'(track_half));
        lft = clamp32(longint'(vx) - turn);
        rgt = clamp32(longint'(vx) + turn);
        ml = lft < 0 ? -lft : lft;
        mr = rgt < 0 ? -rgt : rgt;
        mx = ml > mr ? ml : mr;
        lim = longint'(wheel_limit);
        w.scaled = 1'b0;
        if (mx > lim)
        begin
            lft = (lft * lim) / mx;
            rgt = (rgt * lim) / mx;
            w.scaled = 1'b1;
        end
        w.left_lin = lft[DATA_W-1:0];
        w.right_lin = rgt[DATA_W-1:0];
        w.left_ang = DATA_W'(fixed_mul(lft, longint'(inv_radius)));
        w.right_ang = DATA_W'(fixed_mul(rgt, longint'(inv_radius)));
        return w;
    endfunction

    // register the expected word at the edge that accepts the command
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            wheel_q.push_back(wheel_speeds(speed_x, yaw_rate));
    end

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    endtask

    always @(posedge clk)
    begin
        wheel_word_t w;
        if (rst_n && done)
        begin
            if (wheel_q.size() == 0)
                note_mismatch("unexpected word", 0, 1);
            else
            begin
                w = wheel_q.pop_front();
                if (left_linear !== w.left_lin)
                    note_mismatch("left_linear", w.left_lin, left_linear);
                if (right_linear !== w.right_lin)
                    note_mismatch("right_linear", w.right_lin, right_linear);
                if (left_angular !== w.left_ang)
                    note_mismatch("left_angular", w.left_ang, left_angular);
                if (right_angular !== w.right_ang)
                    note_mismatch("right_angular", w.right_ang, right_angular);
                if (limited !== w.scaled)
                    note_mismatch("limited", w.scaled, limited);
            end
        end
    end

    // called at a rising edge; leaves start high so back to back words need no second assignment
    task automatic send_cmd(input logic signed [DATA_W-1:0] vx,
                            input logic signed [DATA_W-1:0] wz, input int gap);
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        speed_x <= vx;
        yaw_rate <= wz;
        forever
        begin
            @(negedge clk);
            if (!busy)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (wheel_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
        cfg_wen <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_HALF_TRACK: track_half = val;
            CFG_SPEED_LIMIT: wheel_limit = val;
            CFG_RADIUS_RECIP: inv_radius = val;
            default: ;
        endcase
    endtask

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $signed($urandom_range(0, 262143)) - 131072;
            3: return $signed($urandom_range(0, 8388607)) - 4194304;
            4: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                            : 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 1023)) - 512;
        endcase
    endfunction

    function automatic logic [REG_W-1:0] rand_reg();
        case ($urandom_range(0, 4))
            0: return REG_W'($urandom);
            1: return REG_W'($urandom_range(1, 1 << 20));
            2: return REG_W'($urandom_range(1 << 12, 1 << 18));
            3: return REG_FULL - REG_W'($urandom_range(0, 7));
            default: return REG_W'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic test_directed();
        send_cmd(0, 0, 0);
        send_cmd(32'sh7fffffff, 0, 0);
        send_cmd(32'sh80000000, 0, 0);
        send_cmd(0, 32'sh7fffffff, 0);
        send_cmd(0, 32'sh80000000, 1);
        send_cmd(32'sh7fffffff, 32'sh7fffffff, 0);
        send_cmd(32'sh80000000, 32'sh80000000, 0);
        send_cmd(32'sh7fffffff, 32'sh80000000, 2);
        send_cmd(32'sh80000000, 32'sh7fffffff, 0);
        send_cmd(32'sh00010000, 0, 0);          // exactly at the limit, no scaling
        send_cmd(32'sh00010001, 0, 0);          // just above the limit
        send_cmd(32'shffff0000, 0, 0);
        send_cmd(32'shfffeffff, 0, 0);
        send_cmd(32'sh00008000, 32'sh00010000, 0);
        send_cmd(-1, -1, 0);                    // floor rounding of negative products
        send_cmd(1, -1, 0);
        send_cmd(32'shaaaaaaaa, 32'sh55555555, 0);
        send_cmd(32'sh55555555, 32'shaaaaaaaa, 0);
        drain();
    endtask

    task automatic test_register_corners();
        logic [REG_W-1:0] corner[4];
        corner = '{'0, 1, REG_FULL, 31'h2aaaaaaa};
        foreach (corner[i])
        begin
            set_reg(CFG_HALF_TRACK, corner[i]);
            set_reg(CFG_SPEED_LIMIT, corner[(i + 1) % 4]);
            set_reg(CFG_RADIUS_RECIP, corner[(i + 2) % 4]);
            set_reg(CFG_NONE, corner[(i + 3) % 4]);   // must be ignored
            repeat (6)
                send_cmd(rand_word(), rand_word(), rand_gap());
            send_cmd(32'sh80000000, 32'sh7fffffff, 0);
            send_cmd(0, 0, 0);
            drain();
        end
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 0)
            begin
                set_reg(CFG_HALF_TRACK, 6554);
                set_reg(CFG_SPEED_LIMIT, 65536);
                set_reg(CFG_RADIUS_RECIP, 1310720);
            end
            else
            begin
                set_reg(CFG_HALF_TRACK, rand_reg());
                set_reg(CFG_SPEED_LIMIT, rand_reg());
                set_reg(CFG_RADIUS_RECIP, rand_reg());
            end
            for (int n = 0; n < 257; n++)
            begin
                // every so often run a stretch with no gaps
                send_cmd(rand_word(), rand_word(), (n % 60) < 20 ? 0 : rand_gap());
                if (n == 120)
                    drain();
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        speed_x = '0;
        yaw_rate = '0;
        cfg_wen = 1'b0;
        cfg_idx = CFG_HALF_TRACK;
        cfg_wdata = '0;
        track_half = 6554;
        wheel_limit = 65536;
        inv_radius = 1310720;
        mismatches = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_corners();
        test_random_phases();
        repeat (LATENCY + 10)
            @(posedge clk);
        if (mismatches == 0 && wheel_q.size() == 0)
            $display("differential_drive_wheel_speed test passed");
        else
            $display("differential_drive_wheel_speed test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("differential_drive_wheel_speed test failed");
        $finish;
    end
endmodule
